FILE: hdl/sds_pkg.sv
package sds_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	localparam int CYL_W = 16;
	localparam int SUM_W = 22;
	localparam int SIZE_W = 17;
	localparam int ADDR_W = 2;

	localparam logic [ADDR_W-1:0] REG_START_HEAD = 2'd0;
	localparam logic [ADDR_W-1:0] REG_DIRECTION_UP = 2'd1;
	localparam logic [ADDR_W-1:0] REG_DISK_SIZE = 2'd2;

	typedef struct packed {
		logic [CYL_W-1:0] end_cyl;
		logic [CYL_W-1:0] head;
		logic             dir_up;
	} cfg_t;

	typedef struct packed {
		logic             lt;
		logic [CYL_W-1:0] absd;
	} alu_res_t;

	typedef struct packed {
		logic [CYL_W-1:0] target;
		logic [CYL_W-1:0] seek;
		logic [SUM_W-1:0] total;
		logic             boundary;
		logic             last;
	} res_t;

endpackage

FILE: hdl/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler.
// Slave stream: one pending request per item, cylinder in s_axis_tdata, the
// final request of a batch flagged by s_axis_tlast. Requests above the end
// cylinder are clamped; once the store holds MAX_REQUESTS, further requests
// are dropped but their tlast still starts the sweep.
// Master stream: one item per head move: target, seek distance and running
// total in m_axis_tdata, tuser set on the disk-end visit, tlast on the final
// move. A sweep yields n + 1 items for n stored requests.
// Config port: cfg_we / cfg_addr / cfg_wdata, to be written only while idle;
// the user must keep to this, as the block itself does not enforce it.
// Processing: a request is clamped, then insertion-sorted into one memory
// with a single compare unit, larger stored entries shifting up one slot.
// The sweep then scans the sorted list for the split and emits the moves
// in order, each held until the receiver takes it.
// s_axis_tready is low throughout; a stalled receiver holds the current move
// in the output register and the sweep waits.
// Reset: config returns to start 0, upward, 65536 cylinders; the batch is
// emptied. No clearing pass: only written entries are ever used.
module scan_disk_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sds_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [sds_pkg::SIZE_W-1:0]  cfg_wdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // [15:0] request_cylinder
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [15:0] target_cylinder, [31:16] seek_distance, [53:32] total_movement, [55:54] zero
	output logic [55:0]                 m_axis_tdata,
	output logic                        m_axis_tuser,  // [0] is_boundary
	output logic                        m_axis_tlast
);

	logic [sds_pkg::CYL_W-1:0]  start_q;
	logic                       dir_q;
	logic [sds_pkg::SIZE_W-1:0] size_q;
	logic [sds_pkg::CYL_W-1:0]  end_cyl;
	sds_pkg::cfg_t              cfg;
	sds_pkg::res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			dir_q <= 1'b1;
			size_q <= sds_pkg::SIZE_W'(65536);
		end else if (cfg_we) begin
			case (cfg_addr)
				sds_pkg::REG_START_HEAD:   start_q <= cfg_wdata[sds_pkg::CYL_W-1:0];
				sds_pkg::REG_DIRECTION_UP: dir_q <= cfg_wdata[0];
				sds_pkg::REG_DISK_SIZE:    size_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// zero cylinders counts as one; 65536 and up saturate at the top cylinder
	always_comb begin
		if (size_q == '0) begin
			end_cyl = '0;
		end else if (size_q[sds_pkg::SIZE_W-1]) begin
			end_cyl = '1;
		end else begin
			end_cyl = size_q[sds_pkg::CYL_W-1:0] - sds_pkg::CYL_W'(1);
		end
	end

	assign cfg.end_cyl = end_cyl;
	assign cfg.head = (start_q > end_cyl) ? end_cyl : start_q;
	assign cfg.dir_up = dir_q;

	sds_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cyl    (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {2'b00, res.total, res.seek, res.target};
	assign m_axis_tuser = res.boundary;
	assign m_axis_tlast = res.last;

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("input taken while a move is pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not idle after final move");

	a_total_covers_seek: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.total >= sds_pkg::SUM_W'(res.seek)))
		else $error("running total below seek distance");

	a_boundary_target: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			(res.target == (dir_q ? end_cyl : '0)))
		else $error("boundary move not at disk end");
`endif

endmodule

FILE: hdl/sds_alu.sv
module sds_alu (
	input  logic [sds_pkg::CYL_W-1:0] a,
	input  logic [sds_pkg::CYL_W-1:0] b,
	output sds_pkg::alu_res_t         res
);

	logic [sds_pkg::CYL_W:0] diff;

	assign diff = {1'b0, a} - {1'b0, b};
	assign res.lt = diff[sds_pkg::CYL_W];
	assign res.absd = diff[sds_pkg::CYL_W] ? (~diff[sds_pkg::CYL_W-1:0] + 1'b1)
		: diff[sds_pkg::CYL_W-1:0];

endmodule

FILE: hdl/sds_seq.sv
module sds_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sds_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [sds_pkg::CYL_W-1:0] in_cyl,
	input  logic                      in_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output sds_pkg::res_t             out_res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLAMP,
		S_INS_RD,
		S_INS_CMP,
		S_SPL_RD,
		S_SPL_CMP,
		S_EM_NEXT,
		S_EM_CALC,
		S_EM_WAIT
	} state_t;

	typedef enum logic {
		P_FIRST,
		P_SECOND
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [sds_pkg::CYL_W-1:0] mem [sds_pkg::MAX_REQUESTS];
	logic [sds_pkg::CYL_W-1:0] rd_data_q;
	logic [sds_pkg::IDX_W-1:0] rd_addr;
	logic                      mem_we;
	logic [sds_pkg::CYL_W-1:0] mem_wd;

	logic [sds_pkg::CNT_W-1:0] count_q;
	logic [sds_pkg::IDX_W-1:0] j_q;
	logic [sds_pkg::CNT_W-1:0] i_q;
	logic [sds_pkg::CNT_W-1:0] p_q;
	logic [sds_pkg::CNT_W-1:0] split_q;
	logic [sds_pkg::CYL_W-1:0] v_q;
	logic                      last_in_q;
	logic [sds_pkg::CYL_W-1:0] head_q;
	logic [sds_pkg::SUM_W-1:0] sum_q;
	logic [sds_pkg::CYL_W-1:0] tgt_q;
	logic                      bnd_q;
	logic                      lastm_q;
	logic                      out_valid_q;
	sds_pkg::res_t             out_res_q;

	logic [sds_pkg::CYL_W-1:0] alu_a;
	logic [sds_pkg::CYL_W-1:0] alu_b;
	sds_pkg::alu_res_t         alu;

	logic                      asc;
	logic                      exhausted;
	logic [sds_pkg::CNT_W-1:0] p_dec;
	logic [sds_pkg::CYL_W-1:0] tgt;
	logic [sds_pkg::SUM_W-1:0] sum_next;

	sds_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	assign asc = (phase_q == P_FIRST) ? cfg.dir_up : ~cfg.dir_up;
	assign p_dec = p_q - sds_pkg::CNT_W'(1);
	assign exhausted = asc ? (p_q == count_q) : (p_q == '0);
	assign tgt = bnd_q ? tgt_q : rd_data_q;
	assign sum_next = sum_q + sds_pkg::SUM_W'(alu.absd);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_CLAMP: begin
				alu_a = cfg.end_cyl;
				alu_b = v_q;
			end
			S_INS_CMP: begin
				alu_a = v_q;
				alu_b = rd_data_q;
			end
			S_SPL_CMP: begin
				alu_a = cfg.dir_up ? rd_data_q : head_q;
				alu_b = cfg.dir_up ? head_q : rd_data_q;
			end
			S_EM_CALC: begin
				alu_a = tgt;
				alu_b = head_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_INS_RD:  rd_addr = j_q - sds_pkg::IDX_W'(1);
			S_SPL_RD:  rd_addr = i_q[sds_pkg::IDX_W-1:0];
			S_EM_NEXT: rd_addr = asc ? p_q[sds_pkg::IDX_W-1:0] : p_dec[sds_pkg::IDX_W-1:0];
			default:   rd_addr = '0;
		endcase
	end

	// insertion: shift larger entries up one slot, then drop the new one in the hole
	assign mem_we = ((state_q == S_INS_RD) && (j_q == '0)) || (state_q == S_INS_CMP);
	assign mem_wd = ((state_q == S_INS_CMP) && alu.lt) ? rd_data_q : v_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[j_q] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_FIRST;
			count_q <= '0;
			out_valid_q <= 1'b0;
			j_q <= '0;
			i_q <= '0;
			p_q <= '0;
			split_q <= '0;
			v_q <= '0;
			last_in_q <= 1'b0;
			tgt_q <= '0;
			bnd_q <= 1'b0;
			lastm_q <= 1'b0;
			head_q <= '0;
			sum_q <= '0;
			out_res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						v_q <= in_cyl;
						last_in_q <= in_last;
						if (count_q < sds_pkg::CNT_W'(sds_pkg::MAX_REQUESTS)) begin
							j_q <= count_q[sds_pkg::IDX_W-1:0];
							state_q <= S_CLAMP;
						end else if (in_last) begin
							head_q <= cfg.head;
							sum_q <= '0;
							i_q <= '0;
							state_q <= S_SPL_RD;
						end
					end
				end
				S_CLAMP: begin
					if (alu.lt) begin
						v_q <= cfg.end_cyl;
					end
					state_q <= S_INS_RD;
				end
				S_INS_RD: begin
					if (j_q == '0) begin
						count_q <= count_q + sds_pkg::CNT_W'(1);
						if (last_in_q) begin
							head_q <= cfg.head;
							sum_q <= '0;
							i_q <= '0;
							state_q <= S_SPL_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (alu.lt) begin
						j_q <= j_q - sds_pkg::IDX_W'(1);
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + sds_pkg::CNT_W'(1);
						if (last_in_q) begin
							head_q <= cfg.head;
							sum_q <= '0;
							i_q <= '0;
							state_q <= S_SPL_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SPL_RD: begin
					if (i_q == count_q) begin
						split_q <= i_q;
						p_q <= i_q;
						phase_q <= P_FIRST;
						state_q <= S_EM_NEXT;
					end else begin
						state_q <= S_SPL_CMP;
					end
				end
				S_SPL_CMP: begin
					// up: skip entries below head; down: skip entries at or below head
					if (cfg.dir_up ? alu.lt : ~alu.lt) begin
						i_q <= i_q + sds_pkg::CNT_W'(1);
						state_q <= S_SPL_RD;
					end else begin
						split_q <= i_q;
						p_q <= i_q;
						phase_q <= P_FIRST;
						state_q <= S_EM_NEXT;
					end
				end
				S_EM_NEXT: begin
					if (!exhausted) begin
						bnd_q <= 1'b0;
						lastm_q <= (phase_q == P_SECOND) &&
							(asc ? (p_q + sds_pkg::CNT_W'(1) == count_q)
								: (p_q == sds_pkg::CNT_W'(1)));
						p_q <= asc ? p_q + sds_pkg::CNT_W'(1) : p_dec;
						state_q <= S_EM_CALC;
					end else if (phase_q == P_FIRST) begin
						bnd_q <= 1'b1;
						tgt_q <= cfg.dir_up ? cfg.end_cyl : '0;
						lastm_q <= cfg.dir_up ? (split_q == '0) : (split_q == count_q);
						p_q <= split_q;
						phase_q <= P_SECOND;
						state_q <= S_EM_CALC;
					end else begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_EM_CALC: begin
					out_res_q.target <= tgt;
					out_res_q.seek <= alu.absd;
					out_res_q.total <= sum_next;
					out_res_q.boundary <= bnd_q;
					out_res_q.last <= lastm_q;
					out_valid_q <= 1'b1;
					sum_q <= sum_next;
					head_q <= tgt;
					state_q <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (lastm_q) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EM_NEXT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_res = out_res_q;

endmodule
